[rtl/core/mgrv_pkg.sv]
package mgrv_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int GAIN_W        = 16;
    localparam int FRAC_W        = 12;
    localparam int MAG_W         = SAMPLE_W + 1;
    localparam int PROD_W        = 2 * MAG_W;
    localparam int SQ_W          = 2 * SAMPLE_W - 1;
    localparam int RAD_W         = 32;
    localparam int ROOT_W        = RAD_W / 2;
    localparam int LEVEL_SHIFT   = 3;
    localparam int CFG_IDX_W     = 8;
    localparam int MAX_FRAME_DEF = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE   = 8'd2;

    localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd4096;
    localparam logic [SAMPLE_W-1:0] THRESH_RST = 16'd655;

    localparam logic [SAMPLE_W-1:0] POS_MAX = 16'd32767;
    localparam logic [SAMPLE_W-1:0] NEG_MAX = 16'd32768;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_iter_ctl;

endpackage

[rtl/core/mic_gain_rms_vad.sv]
// ordinary sample: IDLE, GAIN, SAT, SQ, ACC, OUT; next request taken only once the result is registered
// last sample of a frame: ACC goes on to DSTART, DWAIT and SWAIT before OUT
// DWAIT runs the bit-serial restoring divider, SWAIT the 2-bit-per-cycle square root
// one multiplier serves the gain product (GAIN state) and the square (SQ state)
// synchronous active-low reset: gain 4096, threshold 655, unmuted, sums and flag cleared
module mic_gain_rms_vad #(
    parameter int MAX_FRAME = mgrv_pkg::MAX_FRAME_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [15:0]                       i_s_tdata,   // sample_in
    input  logic                              i_s_tlast,   // frame_last
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // sample_out, level, rms_value, speaking, speaking_changed, zero pad
    output logic [55:0]                       o_m_tdata,
    output logic                              o_m_tuser,   // level_valid
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mgrv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);
    import mgrv_pkg::*;

    localparam int CW    = $clog2(MAX_FRAME + 1);
    localparam int SUM_W = SQ_W + CW - 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_GAIN   = 4'd1;
    localparam logic [3:0] S_SAT    = 4'd2;
    localparam logic [3:0] S_SQ     = 4'd3;
    localparam logic [3:0] S_ACC    = 4'd4;
    localparam logic [3:0] S_DSTART = 4'd5;
    localparam logic [3:0] S_DWAIT  = 4'd6;
    localparam logic [3:0] S_SWAIT  = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0]          r_state;
    logic [3:0]          n_state;

    logic [GAIN_W-1:0]   r_gain;
    logic [SAMPLE_W-1:0] r_thresh;
    logic                r_muted;

    logic [SUM_W-1:0]    r_sum;
    logic [CW-1:0]       r_cnt;
    logic                r_spk_flag;

    logic                r_neg;
    logic                r_last;
    logic [MAG_W-1:0]    r_mag_in;
    logic [PROD_W-1:0]   r_prod;
    logic [SAMPLE_W-1:0] r_smag;
    logic [SAMPLE_W-1:0] r_sout;
    logic [ROOT_W-1:0]   r_rms;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic                r_out_lv;
    logic [SAMPLE_W-1:0] r_out_level;
    logic [SAMPLE_W-1:0] r_out_rms;
    logic                r_out_spk;
    logic                r_out_chg;

    logic                s_accept;
    logic                out_free;
    logic [MAG_W-1:0]    mul_a;
    logic [MAG_W-1:0]    mul_b;
    logic [20:0]         mag;
    logic [SAMPLE_W-1:0] smag;
    logic [SUM_W-1:0]    n_sum;
    logic [CW-1:0]       n_cnt;
    logic                div_start;
    logic                div_busy;
    logic                div_done;
    logic [SUM_W-1:0]    quotient;
    t_iter_ctl           sq_ctl;
    logic [ROOT_W-1:0]   root;
    logic [ROOT_W-1:0]   rms_c;
    logic [SAMPLE_W-1:0] level_c;
    logic                spk_c;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign out_free    = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RST;
            r_thresh <= THRESH_RST;
            r_muted  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAIN:   r_gain   <= i_cfg_data;
                CFG_THRESH: r_thresh <= i_cfg_data;
                CFG_MUTE:   r_muted  <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // shared multiplier: gain product, then square
    assign mul_a = (r_state == S_GAIN) ? r_mag_in : {1'b0, r_smag};
    assign mul_b = (r_state == S_GAIN) ? {1'b0, r_gain} : {1'b0, r_smag};

    assign mag = r_prod[FRAC_W+20:FRAC_W];
    always_comb begin
        if (r_neg) begin
            smag = (mag > 21'(NEG_MAX)) ? NEG_MAX : mag[SAMPLE_W-1:0];
        end else begin
            smag = (mag > 21'(POS_MAX)) ? POS_MAX : mag[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        if (r_cnt < CW'(MAX_FRAME)) begin
            n_sum = r_sum + SUM_W'(r_prod[SQ_W-1:0]);
            n_cnt = r_cnt + 1'b1;
        end
    end

    assign div_start = (r_state == S_DSTART);

    mgrv_div #(
        .DVD_W (SUM_W),
        .DVS_W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_cnt),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    mgrv_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((r_state == S_DWAIT) && div_done && !div_busy),
        .i_radicand (quotient[RAD_W-1:0]),
        .o_ctl      (sq_ctl),
        .o_root     (root)
    );

    assign rms_c   = (root > ROOT_W'(NEG_MAX)) ? ROOT_W'(NEG_MAX) : root;
    assign level_c = (r_rms[ROOT_W-1:ROOT_W-LEVEL_SHIFT] != '0) ? '1 :
                     {r_rms[ROOT_W-LEVEL_SHIFT-1:0], {LEVEL_SHIFT{1'b0}}};
    assign spk_c   = !r_muted && (r_rms > r_thresh);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (s_accept) n_state = S_GAIN;
            S_GAIN:   n_state = S_SAT;
            S_SAT:    n_state = S_SQ;
            S_SQ:     n_state = S_ACC;
            S_ACC: begin
                if (r_last && (n_cnt != '0)) n_state = S_DSTART;
                else n_state = S_OUT;
            end
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT:  if (div_done) n_state = S_SWAIT;
            S_SWAIT:  if (sq_ctl.done && !sq_ctl.start) n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_spk_flag  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ACC) begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
            end
            if ((r_state == S_DSTART) || ((r_state == S_OUT) && out_free && r_last)) begin
                r_sum <= '0;
                r_cnt <= '0;
            end
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
                if (r_last) r_spk_flag <= spk_c;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_neg    <= i_s_tdata[SAMPLE_W-1];
            r_last   <= i_s_tlast;
            r_mag_in <= i_s_tdata[SAMPLE_W-1] ? (MAG_W'(1) << SAMPLE_W) - {1'b0, i_s_tdata}
                                              : {1'b0, i_s_tdata};
        end
        if ((r_state == S_GAIN) || (r_state == S_SQ)) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_state == S_SAT) begin
            r_smag <= smag;
            r_sout <= r_neg ? (~smag + 1'b1) : smag;
        end
        if (r_state == S_ACC) begin
            r_rms <= '0;
        end else if ((r_state == S_SWAIT) && sq_ctl.done) begin
            r_rms <= rms_c;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out_sample <= r_sout;
            r_out_lv     <= r_last;
            r_out_level  <= r_last ? level_c : '0;
            r_out_rms    <= r_last ? r_rms : '0;
            r_out_spk    <= r_last && spk_c;
            r_out_chg    <= r_last && (spk_c != r_spk_flag);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_lv;
    assign o_m_tdata  = {6'b0, r_out_chg, r_out_spk, r_out_rms, r_out_level, r_out_sample};
endmodule

[rtl/core/mgrv_div.sv]
module mgrv_div #(
    parameter int DVD_W = 41,
    parameter int DVS_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int IT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [IT_W-1:0]  r_it;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_it   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_it   <= IT_W'(DVD_W);
            end else if (r_busy) begin
                r_it <= r_it - 1'b1;
                if (r_it == IT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

[rtl/core/mgrv_isqrt.sv]
module mgrv_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mgrv_pkg::RAD_W-1:0]   i_radicand,
    output mgrv_pkg::t_iter_ctl          o_ctl,
    output logic [mgrv_pkg::ROOT_W-1:0]  o_root
);
    import mgrv_pkg::*;

    localparam int IT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [IT_W-1:0]   r_it;
    logic              r_busy;
    logic              r_done;

    logic [ROOT_W+1:0] trial;
    logic [ROOT_W+1:0] cand;
    logic [ROOT_W+1:0] diff;
    logic              ge;

    assign trial = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1:RAD_W-2]};
    assign cand  = {r_root, 2'b01};
    assign diff  = trial - cand;
    assign ge    = (trial >= cand);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_it   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_it   <= IT_W'(ROOT_W);
            end else if (r_busy) begin
                r_it <= r_it - 1'b1;
                if (r_it == IT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= ge ? diff : trial;
            r_root <= {r_root[ROOT_W-2:0], ge};
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;
    assign o_root      = r_root;
endmodule

[tb/mic_gain_rms_vad_tb.sv]
module mic_gain_rms_vad_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mgrv_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RST_CYCLES   = 6;
    localparam int GAP_MAX      = 5;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_ITEMS   = 40;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1070;
    localparam int LONG_FRAME   = MAX_FRAME_DEF + 2;
    localparam int PRINT_CAP    = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP   = 8'hFF;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;
    typedef enum logic [1:0] {AMP_FULL, AMP_NEAR_THRESH, AMP_EXTREME, AMP_MID} amp_kind_e;

    typedef struct packed {
        logic [15:0] sample_out;
        logic        level_valid;
        logic [15:0] level;
        logic [15:0] rms;
        logic        speaking;
        logic        changed;
    } gain_result_t;

    typedef struct packed {
        row_kind_e              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [15:0]            val;
        logic [15:0]            smp;
        logic                   is_last;
        logic                   known;
        gain_result_t           want;
    } stim_row_t;

    logic                 i_clk     = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_valid   = 1'b0;
    logic [15:0]          s_data    = '0;
    logic                 s_last    = 1'b0;
    logic                 m_ready   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;

    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [55:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_cfg_ready;

    // predictor copy of registers and frame state
    logic [15:0] gain_reg   = GAIN_RST;
    logic [15:0] thresh_reg = THRESH_RST;
    logic        mute_reg   = 1'b0;
    logic [40:0] sq_acc     = '0;
    int          frame_n    = 0;
    logic        spk_prev   = 1'b0;

    gain_result_t pending_results[$];
    stim_row_t    dir_rows[$];

    logic src_idle    = 1'b1;
    logic sink_idle   = 1'b1;
    int   hold_asked  = 0;
    int   hold_done   = 0;

    int cycle_count     = 0;
    int mismatch_count  = 0;
    int results_checked = 0;
    int samples_sent    = 0;
    int frames_sent     = 0;
    int reg_writes      = 0;
    int over_cap_frames = 0;

    mic_gain_rms_vad u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),
        .i_s_tlast   (s_last),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic gain_result_t scale_and_meter(logic [15:0] raw, logic is_last);
        gain_result_t r;
        logic         neg;
        logic [63:0]  mag_in;
        logic [63:0]  mag;
        logic [63:0]  lim;
        logic [63:0]  mean;
        logic [63:0]  root;
        logic [63:0]  cand;
        logic [63:0]  lvl;
        neg    = raw[15];
        mag_in = neg ? (64'h10000 - 64'(raw)) : 64'(raw);
        mag    = (mag_in * 64'(gain_reg)) >> FRAC_W;
        lim    = neg ? 64'(NEG_MAX) : 64'(POS_MAX);
        if (mag > lim) begin
            mag = lim;
        end
        r = '0;
        r.sample_out = neg ? 16'(64'h10000 - mag) : mag[15:0];
        if (frame_n < MAX_FRAME_DEF) begin
            sq_acc  = sq_acc + 41'(mag * mag);
            frame_n = frame_n + 1;
        end
        if (is_last) begin
            mean = (frame_n != 0) ? (64'(sq_acc) / 64'(frame_n)) : 64'd0;
            root = '0;
            for (int b = 16; b >= 0; b--) begin
                cand = root | (64'd1 << b);
                if (cand * cand <= mean) begin
                    root = cand;
                end
            end
            if (root > 64'(NEG_MAX)) begin
                root = 64'(NEG_MAX);
            end
            lvl = root << LEVEL_SHIFT;
            if (lvl > 64'hFFFF) begin
                lvl = 64'hFFFF;
            end
            r.level_valid = 1'b1;
            r.level       = lvl[15:0];
            r.rms         = root[15:0];
            r.speaking    = !mute_reg && (root > 64'(thresh_reg));
            r.changed     = (r.speaking != spk_prev);
            spk_prev      = r.speaking;
            sq_acc        = '0;
            frame_n       = 0;
        end
        return r;
    endfunction

    function automatic logic [15:0] gen_sample(amp_kind_e kind);
        int amp;
        case (kind)
            AMP_FULL: begin
                return 16'($urandom());
            end
            AMP_NEAR_THRESH: begin
                amp = $urandom_range(0, 2000);
                return 16'($urandom_range(0, 2 * amp) - amp);
            end
            AMP_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return POS_MAX;
                    1: return NEG_MAX;
                    2: return 16'h0000;
                    3: return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            default: begin
                amp = 8000;
                return 16'($urandom_range(0, 2 * amp) - amp);
            end
        endcase
    endfunction

    function automatic void row_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.val  = val;
        dir_rows.push_back(row);
    endfunction

    function automatic void row_smp(logic [15:0] smp, logic is_last);
        stim_row_t row;
        row         = '0;
        row.kind    = ROW_SAMPLE;
        row.smp     = smp;
        row.is_last = is_last;
        dir_rows.push_back(row);
    endfunction

    function automatic void row_chk(logic [15:0] smp, logic is_last, logic [15:0] so,
                                    logic lv, logic [15:0] lvl, logic [15:0] rms,
                                    logic spk, logic chg);
        stim_row_t row;
        row                  = '0;
        row.kind             = ROW_SAMPLE;
        row.smp              = smp;
        row.is_last          = is_last;
        row.known            = 1'b1;
        row.want.sample_out  = so;
        row.want.level_valid = lv;
        row.want.level       = lvl;
        row.want.rms         = rms;
        row.want.speaking    = spk;
        row.want.changed     = chg;
        dir_rows.push_back(row);
    endfunction

    task report_mismatch(string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("mismatch at result %0d: %s", results_checked, msg);
        end
        mismatch_count++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_GAIN:   gain_reg   = val;
            CFG_THRESH: thresh_reg = val;
            CFG_MUTE:   mute_reg   = val[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        reg_writes++;
        @(posedge i_clk);
    endtask

    // one request per sample, expectation stored at acceptance
    task automatic send_sample(logic [15:0] smp, logic is_last, logic known,
                               gain_result_t want);
        int           gap;
        gain_result_t pred;
        gap = src_idle ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        s_last  <= is_last;
        do @(posedge i_clk); while (!o_s_tready);
        pred = scale_and_meter(smp, is_last);
        pending_results.push_back(known ? want : pred);
        samples_sent++;
        if (is_last) begin
            frames_sent++;
        end
    endtask

    task automatic send_frame(int len, amp_kind_e kind);
        for (int i = 0; i < len; i++) begin
            send_sample(gen_sample(kind), i == len - 1, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        stim_row_t   row;
        int          p;
        int          n;
        int          len;
        int          target;
        int          random_items;
        logic [15:0] gain_val;
        logic [15:0] thr_val;
        logic        mute_val;

        // after reset and full-scale extremes
        row_chk(16'h0000, 1'b1, 16'h0000, 1'b1, 16'd0, 16'd0, 1'b0, 1'b0);
        row_chk(NEG_MAX, 1'b1, NEG_MAX, 1'b1, 16'hFFFF, 16'd32768, 1'b1, 1'b1);
        row_chk(POS_MAX, 1'b1, POS_MAX, 1'b1, 16'hFFFF, 16'd32767, 1'b1, 1'b0);
        row_chk(16'd1000, 1'b0, 16'd1000, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        row_smp(16'hFC18, 1'b1);
        // maximum gain saturates
        row_cfg(CFG_GAIN, 16'hFFFF);
        row_chk(POS_MAX, 1'b1, POS_MAX, 1'b1, 16'hFFFF, 16'd32767, 1'b1, 1'b0);
        row_smp(16'hFFFF, 1'b1);
        row_smp(NEG_MAX, 1'b0);
        row_smp(16'd12345, 1'b1);
        // zero gain
        row_cfg(CFG_GAIN, 16'h0000);
        row_smp(NEG_MAX, 1'b1);
        // threshold extremes
        row_cfg(CFG_GAIN, GAIN_RST);
        row_cfg(CFG_THRESH, 16'd32768);
        row_chk(NEG_MAX, 1'b1, NEG_MAX, 1'b1, 16'hFFFF, 16'd32768, 1'b0, 1'b0);
        row_cfg(CFG_THRESH, 16'd0);
        row_chk(16'd1, 1'b1, 16'd1, 1'b1, 16'd8, 16'd1, 1'b1, 1'b1);
        row_chk(16'd0, 1'b1, 16'd0, 1'b1, 16'd0, 16'd0, 1'b0, 1'b1);
        // muted
        row_cfg(CFG_MUTE, 16'd1);
        row_chk(NEG_MAX, 1'b1, NEG_MAX, 1'b1, 16'hFFFF, 16'd32768, 1'b0, 1'b0);
        row_smp(16'd20000, 1'b0);
        row_smp(16'hB1E0, 1'b1);
        // unused indexes leave the registers alone
        row_cfg(CFG_SPARE, 16'hFFFF);
        row_cfg(CFG_TOP, 16'h1234);
        row_cfg(CFG_MUTE, 16'd0);
        row_cfg(CFG_THRESH, THRESH_RST);
        row_smp(16'h5555, 1'b0);
        row_smp(16'hAAAA, 1'b0);
        row_smp(POS_MAX, 1'b0);
        row_smp(NEG_MAX, 1'b1);

        repeat (RST_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.kind == ROW_CFG) begin
                write_reg(row.idx, row.val);
            end else begin
                send_sample(row.smp, row.is_last, row.known, row.want);
            end
        end

        p            = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0:       gain_val = GAIN_RST;
                1:       gain_val = 16'($urandom());
                2:       gain_val = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                default: gain_val = 16'($urandom_range(2048, 8192));
            endcase
            case ($urandom_range(0, 3))
                0:       thr_val = THRESH_RST;
                1:       thr_val = 16'($urandom_range(0, 32768));
                2:       thr_val = ($urandom_range(0, 1) != 0) ? 16'd32768 : 16'd0;
                default: thr_val = 16'($urandom_range(0, 2000));
            endcase
            mute_val = ($urandom_range(0, 3) == 0);
            write_reg(CFG_GAIN, gain_val);
            write_reg(CFG_THRESH, thr_val);
            write_reg(CFG_MUTE, {15'd0, mute_val});
            if (p % 5 == 4) begin
                write_reg(8'($urandom_range(3, 255)), 16'($urandom()));
            end

            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);

            if (p == 3) begin
                // output held off while input runs back to back
                src_idle = 1'b0;
                hold_asked++;
                repeat (HOLD_ITEMS) begin
                    send_sample(gen_sample(AMP_FULL), $urandom_range(0, 7) == 0, 1'b0, '0);
                end
                send_sample(gen_sample(AMP_MID), 1'b1, 1'b0, '0);
                random_items += HOLD_ITEMS + 1;
            end
            if (p == 6) begin
                send_frame(LONG_FRAME, AMP_FULL);
                over_cap_frames++;
                random_items += LONG_FRAME;
            end

            n      = 0;
            target = $urandom_range(4, 16);
            while (n < target) begin
                len = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 16)
                                                  : $urandom_range(17, 64);
                send_frame(len, amp_kind_e'($urandom_range(0, 3)));
                n += len;
            end
            random_items += n;
            p++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("run: %0d samples in %0d frames, %0d over the frame cap, %0d register writes",
                 samples_sent, frames_sent, over_cap_frames, reg_writes);
        $display("run: %0d results compared, %0d mismatches, one %0d-cycle output stall",
                 results_checked, mismatch_count, HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : sink
        int gap;
        wait (rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_done != hold_asked) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done++;
            end else begin
                gap = sink_idle ? $urandom_range(0, GAP_MAX) : 0;
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    always @(posedge i_clk) begin : result_check
        gain_result_t got;
        gain_result_t want;
        if (rst_n && o_m_tvalid && m_ready) begin
            got.sample_out  = o_m_tdata[15:0];
            got.level       = o_m_tdata[31:16];
            got.rms         = o_m_tdata[47:32];
            got.speaking    = o_m_tdata[48];
            got.changed     = o_m_tdata[49];
            got.level_valid = o_m_tuser;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, sample_out %0d",
                                          $signed(got.sample_out)));
            end else begin
                want = pending_results.pop_front();
                if (got.sample_out !== want.sample_out) begin
                    report_mismatch($sformatf("sample_out %0d expected %0d",
                                              $signed(got.sample_out),
                                              $signed(want.sample_out)));
                end
                if (got.level_valid !== want.level_valid) begin
                    report_mismatch($sformatf("level_valid %0b expected %0b",
                                              got.level_valid, want.level_valid));
                end
                if (got.level !== want.level) begin
                    report_mismatch($sformatf("level %0d expected %0d",
                                              got.level, want.level));
                end
                if (got.rms !== want.rms) begin
                    report_mismatch($sformatf("rms_value %0d expected %0d",
                                              got.rms, want.rms));
                end
                if (got.speaking !== want.speaking) begin
                    report_mismatch($sformatf("speaking %0b expected %0b",
                                              got.speaking, want.speaking));
                end
                if (got.changed !== want.changed) begin
                    report_mismatch($sformatf("speaking_changed %0b expected %0b",
                                              got.changed, want.changed));
                end
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

[filelist.f]
rtl/core/mgrv_pkg.sv
rtl/core/mgrv_div.sv
rtl/core/mgrv_isqrt.sv
rtl/core/mic_gain_rms_vad.sv
tb/mic_gain_rms_vad_tb.sv
